// ===== design/idrr_pkg.sv =====
// ----------------------------------------------------------------------------
// idrr_pkg: shared definitions for the id renumber / reference remap core
// Sizes, payload types, state encodings and the control structs that pass
// between the scan engine and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package idrr_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned ID_W        = 11;
  localparam int unsigned EXT_W       = (CNT_W > ID_W) ? CNT_W : ID_W;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_OVF
  } ctl_state_e;

  typedef enum logic {
    SCN_IDLE,
    SCN_RUN
  } scn_state_e;

  typedef struct packed {
    logic start;
    logic ack;
    cnt_t pos;
  } scan_req_t;

  typedef struct packed {
    logic  done;
    logic  rep_hit;
    logic  grp_hit;
    addr_t rep_pos;
    addr_t grp_pos;
  } scan_rsp_t;

  // A count is reported modulo 2**ID_W.
  function automatic id_t cnt_to_id(cnt_t c);
    logic [EXT_W-1:0] w;
    w = EXT_W'(c);
    return w[ID_W-1:0];
  endfunction

  // A memory position p is reported as p + 1.
  function automatic id_t addr_to_id(addr_t a);
    cnt_t c;
    c = CNT_W'(a) + CNT_W'(1);
    return cnt_to_id(c);
  endfunction

endpackage

`default_nettype wire

// ===== design/idrr_ram.sv =====
// ----------------------------------------------------------------------------
// idrr_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module idrr_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/idrr_scan.sv =====
// ----------------------------------------------------------------------------
// idrr_scan: search engine over the id and group memories
// Walks the id memory downward for the latest matching old id and the group
// memory upward for the first matching old group, one read per cycle each.
// ----------------------------------------------------------------------------
`default_nettype none

module idrr_scan import idrr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire scan_req_t req_i,
  input  wire key_t      rep_key_i,
  input  wire key_t      grp_key_i,
  output logic           rep_re_o,
  output addr_t          rep_raddr_o,
  input  wire key_t      rep_rdata_i,
  output logic           grp_re_o,
  output addr_t          grp_raddr_o,
  input  wire key_t      grp_rdata_i,
  output scan_rsp_t      rsp_o
);

  scn_state_e state_q, state_d;

  key_t  rep_key_q, grp_key_q;
  cnt_t  rep_left_q, grp_left_q;
  addr_t rep_addr_q, grp_addr_q;
  addr_t rep_tag_q, grp_tag_q;
  logic  rep_pend_q, grp_pend_q;
  logic  rep_hit_q, grp_hit_q;

  logic  launch;
  logic  rep_match, grp_match;
  logic  rep_issue, grp_issue;
  logic  rep_fin, grp_fin, all_done;

  assign launch    = (state_q == SCN_IDLE) && req_i.start;
  assign rep_match = rep_pend_q && !rep_hit_q && (rep_rdata_i == rep_key_q);
  assign grp_match = grp_pend_q && !grp_hit_q && (grp_rdata_i == grp_key_q);
  assign rep_issue = (state_q == SCN_RUN) && (rep_left_q != '0) && !rep_hit_q && !rep_match;
  assign grp_issue = (state_q == SCN_RUN) && (grp_left_q != '0) && !grp_hit_q && !grp_match;
  assign rep_fin   = rep_hit_q || ((rep_left_q == '0) && !rep_pend_q);
  assign grp_fin   = grp_hit_q || ((grp_left_q == '0) && !grp_pend_q);
  assign all_done  = (state_q == SCN_RUN) && rep_fin && grp_fin;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SCN_IDLE: if (req_i.start) state_d = SCN_RUN;
      SCN_RUN:  if (all_done && req_i.ack) state_d = SCN_IDLE;
      default:  state_d = SCN_IDLE;
    endcase
  end

  always_comb begin
    rep_re_o      = rep_issue;
    rep_raddr_o   = rep_addr_q;
    grp_re_o      = grp_issue;
    grp_raddr_o   = grp_addr_q;
    rsp_o.done    = all_done;
    rsp_o.rep_hit = rep_hit_q;
    rsp_o.grp_hit = grp_hit_q;
    rsp_o.rep_pos = rep_tag_q;
    rsp_o.grp_pos = grp_tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SCN_IDLE;
      rep_left_q <= '0;
      grp_left_q <= '0;
      rep_pend_q <= 1'b0;
      grp_pend_q <= 1'b0;
      rep_hit_q  <= 1'b0;
      grp_hit_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rep_pend_q <= rep_issue;
      grp_pend_q <= grp_issue;
      if (launch) begin
        rep_left_q <= req_i.pos;
        grp_left_q <= req_i.pos;
        rep_hit_q  <= 1'b0;
        grp_hit_q  <= 1'b0;
      end else begin
        if (rep_issue) rep_left_q <= rep_left_q - CNT_W'(1);
        if (grp_issue) grp_left_q <= grp_left_q - CNT_W'(1);
        if (rep_match) rep_hit_q <= 1'b1;
        if (grp_match) grp_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      rep_key_q  <= rep_key_i;
      grp_key_q  <= grp_key_i;
      rep_addr_q <= req_i.pos[ADDR_W-1:0] - ADDR_W'(1);
      grp_addr_q <= '0;
    end else begin
      if (rep_issue) begin
        rep_addr_q <= rep_addr_q - ADDR_W'(1);
        rep_tag_q  <= rep_addr_q;
      end
      if (grp_issue) begin
        grp_addr_q <= grp_addr_q + ADDR_W'(1);
        grp_tag_q  <= grp_addr_q;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/id_renumber_reference_remap_core.sv =====
// ----------------------------------------------------------------------------
// id_renumber_reference_remap_core: dense record renumbering
// Numbers records densely, remaps reply-to ids to the latest earlier record
// with that old id, and groups to the first record with the same old group.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid_i/in_ready_o | old_id, old_group, old_reply, last
//  out     | output    | out_valid_o/out_ready_i | new_id, new_reply, new_group, ovf
//
//  Both searches read one memory entry per cycle, so the time from a record's
//  input beat until its result is ready grows with its position p: the
//  longer of the two walks over the p stored entries sets it.
//  A dropped record (store full) is not searched.
//  Reset empties the list at once; the memories need no clearing because
//  only entries below the current count are ever read.
//  A stalled output holds its result register; the next input beat is taken
//  while it waits, and its own search stalls at the end until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module id_renumber_reference_remap_core import idrr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire key_t old_id_i,
  input  wire key_t old_group_i,
  input  wire key_t old_reply_i,
  input  wire logic last_entry_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output id_t       new_id_o,
  output id_t       new_reply_o,
  output id_t       new_group_o,
  output logic      overflow_o
);

  ctl_state_e state_q, state_d;

  // Number of records stored in the current list, and the position of the
  // record now being searched.
  cnt_t count_q;
  cnt_t pos_q;

  logic out_valid_q;
  id_t  new_id_q, new_reply_q, new_group_q;
  logic overflow_q;

  logic      full, accept, out_free, load_out, store_we;
  scan_req_t scan_req;
  scan_rsp_t scan_rsp;

  logic  rep_re, grp_re;
  addr_t rep_raddr, grp_raddr;
  key_t  rep_rdata, grp_rdata;

  id_t nid, nrep, ngrp;

  assign full     = (count_q == CNT_W'(MAX_ENTRIES));
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign store_we = accept && !full;

  // Both old ids and old groups of a stored record are written at its input
  // beat. Searches only read positions below it, so no forwarding is needed.
  idrr_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (KEY_W)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (old_id_i),
    .re_i    (rep_re),
    .raddr_i (rep_raddr),
    .rdata_o (rep_rdata)
  );

  idrr_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (KEY_W)
  ) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (old_group_i),
    .re_i    (grp_re),
    .raddr_i (grp_raddr),
    .rdata_o (grp_rdata)
  );

  idrr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (scan_req),
    .rep_key_i   (old_reply_i),
    .grp_key_i   (old_group_i),
    .rep_re_o    (rep_re),
    .rep_raddr_o (rep_raddr),
    .rep_rdata_i (rep_rdata),
    .grp_re_o    (grp_re),
    .grp_raddr_o (grp_raddr),
    .grp_rdata_i (grp_rdata),
    .rsp_o       (scan_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTL_IDLE: begin
        if (accept) state_d = full ? CTL_OVF : CTL_SCAN;
      end
      CTL_SCAN: begin
        if (scan_rsp.done && out_free) state_d = CTL_IDLE;
      end
      CTL_OVF: begin
        if (out_free) state_d = CTL_IDLE;
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready_o     = 1'b0;
    load_out       = 1'b0;
    scan_req.start = 1'b0;
    scan_req.ack   = out_free;
    scan_req.pos   = count_q;
    unique case (state_q)
      CTL_IDLE: begin
        in_ready_o     = 1'b1;
        scan_req.start = store_we;
      end
      CTL_SCAN: load_out = scan_rsp.done && out_free;
      CTL_OVF:  load_out = out_free;
      default:  load_out = 1'b0;
    endcase
  end

  // An unmatched reply points back at the record itself, and the group search
  // only covers earlier records because the record always matches its own group.
  assign nid  = cnt_to_id(pos_q + CNT_W'(1));
  assign nrep = scan_rsp.rep_hit ? addr_to_id(scan_rsp.rep_pos) : nid;
  assign ngrp = scan_rsp.grp_hit ? addr_to_id(scan_rsp.grp_pos) : nid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (last_entry_i) begin
          count_q <= '0;
        end else if (!full) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= count_q;
    end
    if (load_out) begin
      if (state_q == CTL_OVF) begin
        new_id_q    <= '0;
        new_reply_q <= '0;
        new_group_q <= '0;
        overflow_q  <= 1'b1;
      end else begin
        new_id_q    <= nid;
        new_reply_q <= nrep;
        new_group_q <= ngrp;
        overflow_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_id_o    = new_id_q;
  assign new_reply_o = new_reply_q;
  assign new_group_o = new_group_q;
  assign overflow_o  = overflow_q;

`ifndef SYNTHESIS
  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (count_q < CNT_W'(MAX_ENTRIES)))
    else $error("record stored beyond the memory depth");

  a_done_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> (state_q == CTL_SCAN))
    else $error("search finished while no record was being searched");

  a_overflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (new_id_o == '0 && new_reply_o == '0 && new_group_o == '0))
    else $error("dropped record carries nonzero ids");

  a_refs_not_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !overflow_o && MAX_ENTRIES < (1 << ID_W)) |->
      (new_id_o != '0 && new_reply_o <= new_id_o && new_group_o <= new_id_o))
    else $error("remapped reference points past the record itself");

  a_load_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result register overwritten while still held");
`endif

endmodule

`default_nettype wire
